[sv/sst_pkg.sv]
// types, codes and constants shared by the sustained threshold trigger
package sst_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int HOLD_W      = 36;

   localparam logic [CSR_INDEX_W-1:0] CSR_RULE_SUPPORTED    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMPARE_LESS_THAN = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD         = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REARM_LEVEL       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_MS           = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_BUDGET     = 3'd5;

   localparam logic [19:0] NS_PER_MS = 20'd1000000;

   localparam logic MODE_FINISH = 1'b1;

   localparam logic [1:0] SAMPLE_FRESH   = 2'd0;
   localparam logic [1:0] SAMPLE_MISSING = 2'd1;
   localparam logic [1:0] SAMPLE_STALE   = 2'd2;
   localparam logic [1:0] SAMPLE_UNDEF   = 2'd3;

   localparam logic [6:0]  OPENED_MAX = 7'd127;
   localparam logic [31:0] FRESH_MAX  = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      PH_INACTIVE = 3'd0,
      PH_WARMING  = 3'd1,
      PH_ARMED    = 3'd2,
      PH_PENDING  = 3'd3,
      PH_OPENING  = 3'd4,
      PH_BLACKOUT = 3'd5,
      PH_RECOVERY = 3'd6,
      PH_REARM    = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      OC_NONE        = 3'd0,
      OC_NEVER       = 3'd1,
      OC_FIRED       = 3'd2,
      OC_EXHAUSTED   = 3'd3,
      OC_UNSUPPORTED = 3'd4
   } outcome_type;

   typedef enum logic [2:0] {
      RS_NONE         = 3'd0,
      RS_DROPPED      = 3'd1,
      RS_REFUSED      = 3'd2,
      RS_UNSUPPORTED  = 3'd3,
      RS_UNREGISTERED = 3'd4,
      RS_NO_REPORTS   = 3'd5,
      RS_NEVER_HELD   = 3'd6
   } reason_type;

   typedef struct packed {
      logic               mode;
      logic               win_open;
      logic [31:0]        open_count;
      logic [31:0]        recent_token;
      logic [31:0]        queued_token;
      logic [31:0]        offered_token;
      logic [1:0]         sample_state;
      logic [31:0]        sample_sequence;
      logic signed [31:0] sample_value;
      logic [62:0]        sample_time_ns;
   } req_type;

   typedef struct packed {
      logic               open_request;
      logic [62:0]        trigger_first_true_ns;
      logic               reset_epoch;
      logic [2:0]         rule_state;
      logic [2:0]         outcome;
      logic [2:0]         reason_code;
      logic [6:0]         windows_opened;
      logic [31:0]        fresh_total;
      logic [31:0]        change_total;
      logic signed [31:0] recent_value;
      logic [62:0]        recent_stamp_ns;
      logic [1:0]         last_sample_state;
   } rsp_type;

   typedef struct packed {
      logic               compare_less_than;
      logic signed [31:0] threshold;
      logic signed [31:0] rearm_level;
      logic [HOLD_W-1:0]  hold_ns;
      logic [6:0]         window_budget;
   } cfg_type;

   typedef struct packed {
      phase_type          phase;
      logic [62:0]        first_true_time;
      logic               first_true_valid;
      logic [31:0]        pending_token;
      logic [6:0]         opened_count;
      outcome_type        outcome;
      reason_type         reason;
      logic [31:0]        opens_seen;
      logic               opens_seen_valid;
      logic               window_was_open;
      logic [31:0]        last_seq;
      logic               last_seq_valid;
      logic [31:0]        fresh_count;
      logic signed [31:0] last_val;
      logic [62:0]        last_time;
      logic [1:0]         last_freshness;
      logic [31:0]        change_count;
   } state_type;

endpackage

[sv/sst_rule.sv]
// rule evaluation: next state and result for one item
module sst_rule (
   input  sst_pkg::state_type st,
   input  sst_pkg::req_type   item,
   input  sst_pkg::cfg_type   cfg,
   output sst_pkg::state_type nx,
   output sst_pkg::rsp_type   rsp
);
   import sst_pkg::*;

   logic        done;
   logic [2:0]  inc;
   logic        req;
   logic [62:0] ft;
   logic        rep;
   logic        missed;
   logic [1:0]  sstate;
   logic        cond;
   logic        rearm;
   logic [62:0] span;
   outcome_type fin_outcome;
   reason_type  fin_reason;

   always_comb begin
      cond  = cfg.compare_less_than ? (item.sample_value < cfg.threshold)
                                    : (item.sample_value > cfg.threshold);
      rearm = cfg.compare_less_than ? (item.sample_value >= cfg.rearm_level)
                                    : (item.sample_value <= cfg.rearm_level);
      span  = item.sample_time_ns - st.first_true_time;
   end

   always_comb begin
      nx     = st;
      done   = 1'b0;
      inc    = 3'd0;
      req    = 1'b0;
      ft     = '0;
      rep    = 1'b0;
      missed = 1'b0;
      sstate = item.sample_state;
      fin_outcome = st.outcome;
      fin_reason  = st.reason;

      if (item.mode == MODE_FINISH) begin
         inc = 3'd1;
         if (st.outcome == OC_UNSUPPORTED || st.outcome == OC_EXHAUSTED) begin
            fin_outcome = st.outcome;
         end else if (st.opened_count != 7'd0) begin
            fin_outcome = OC_FIRED;
         end else begin
            fin_outcome = OC_NEVER;
            if (st.reason == RS_NONE) begin
               if (st.last_freshness == SAMPLE_MISSING) begin
                  fin_reason = RS_UNREGISTERED;
               end else if (st.fresh_count == 32'd0) begin
                  fin_reason = RS_NO_REPORTS;
               end else begin
                  fin_reason = RS_NEVER_HELD;
               end
            end
         end
      end else if (st.phase != PH_INACTIVE) begin
         missed = st.opens_seen_valid && (item.open_count != st.opens_seen)
                  && !item.win_open;
         nx.opens_seen       = item.open_count;
         nx.opens_seen_valid = 1'b1;

         if (st.phase == PH_OPENING) begin
            if (st.pending_token != 32'd0 && item.recent_token == st.pending_token) begin
               nx.pending_token = '0;
               if (st.opened_count < OPENED_MAX) begin
                  nx.opened_count = st.opened_count + 7'd1;
               end
               if (nx.opened_count >= cfg.window_budget) begin
                  nx.outcome = OC_EXHAUSTED;
               end
               nx.first_true_valid = 1'b0;
               nx.phase            = PH_BLACKOUT;
               inc                 = inc + 3'd1;
               nx.window_was_open  = 1'b1;
               done                = 1'b1;
            end else if (item.queued_token != st.pending_token) begin
               nx.pending_token    = '0;
               nx.reason           = RS_DROPPED;
               nx.first_true_valid = 1'b0;
               nx.phase            = PH_ARMED;
               inc                 = inc + 3'd1;
            end
         end

         if (!done && item.win_open) begin
            if (nx.phase != PH_BLACKOUT) begin
               nx.first_true_valid = 1'b0;
               nx.phase            = PH_BLACKOUT;
               inc                 = inc + 3'd1;
            end
            nx.window_was_open = 1'b1;
            done               = 1'b1;
         end

         if (!done && (st.window_was_open || missed)) begin
            nx.window_was_open = 1'b0;
            rep                = 1'b1;
            if (nx.outcome == OC_EXHAUSTED) begin
               nx.phase = PH_INACTIVE;
               done     = 1'b1;
            end else begin
               nx.phase = PH_RECOVERY;
            end
            inc = inc + 3'd1;
         end

         if (!done) begin
            if (sstate == SAMPLE_UNDEF) begin
               sstate = SAMPLE_STALE;
            end
            nx.last_freshness = sstate;
            if (sstate != SAMPLE_FRESH) begin
               if (nx.phase == PH_PENDING) begin
                  nx.first_true_valid = 1'b0;
                  nx.phase            = PH_ARMED;
                  inc                 = inc + 3'd1;
               end
               done = 1'b1;
            end
         end

         if (!done && st.last_seq_valid && item.sample_sequence == st.last_seq) begin
            done = 1'b1;
         end

         if (!done) begin
            nx.last_seq       = item.sample_sequence;
            nx.last_seq_valid = 1'b1;
            if (st.fresh_count != FRESH_MAX) begin
               nx.fresh_count = st.fresh_count + 32'd1;
            end
            nx.last_val  = item.sample_value;
            nx.last_time = item.sample_time_ns;

            case (nx.phase)
               PH_WARMING: begin
                  nx.phase = PH_ARMED;
                  inc      = inc + 3'd1;
               end
               PH_RECOVERY: begin
                  nx.phase = PH_REARM;
                  inc      = inc + 3'd1;
                  if (rearm) begin
                     nx.first_true_valid = 1'b0;
                     nx.phase            = PH_ARMED;
                     inc                 = inc + 3'd1;
                  end
               end
               PH_REARM: begin
                  if (rearm) begin
                     nx.first_true_valid = 1'b0;
                     nx.phase            = PH_ARMED;
                     inc                 = inc + 3'd1;
                  end
               end
               PH_ARMED: begin
                  if (cond) begin
                     nx.first_true_time  = item.sample_time_ns;
                     nx.first_true_valid = 1'b1;
                     nx.phase            = PH_PENDING;
                     inc                 = inc + 3'd1;
                     if (cfg.hold_ns == '0) begin
                        req = 1'b1;
                     end
                  end
               end
               PH_PENDING: begin
                  if (!cond) begin
                     nx.first_true_valid = 1'b0;
                     nx.phase            = PH_ARMED;
                     inc                 = inc + 3'd1;
                  end else if (!st.first_true_valid) begin
                     nx.first_true_time  = item.sample_time_ns;
                     nx.first_true_valid = 1'b1;
                  end else if (item.sample_time_ns >= st.first_true_time &&
                               span >= {{(63-HOLD_W){1'b0}}, cfg.hold_ns}) begin
                     req = 1'b1;
                  end
               end
               default: begin
               end
            endcase

            // open request to the coordinator
            if (req) begin
               ft               = nx.first_true_time;
               nx.pending_token = item.offered_token;
               inc              = inc + 3'd1;
               if (item.offered_token != 32'd0) begin
                  nx.phase = PH_OPENING;
               end else begin
                  nx.reason           = RS_REFUSED;
                  nx.first_true_valid = 1'b0;
                  nx.phase            = PH_ARMED;
               end
            end
         end
      end

      nx.change_count = st.change_count + {29'd0, inc};

      rsp.open_request          = req;
      rsp.trigger_first_true_ns = ft;
      rsp.reset_epoch           = rep;
      rsp.rule_state            = nx.phase;
      rsp.outcome               = (item.mode == MODE_FINISH) ? fin_outcome : nx.outcome;
      rsp.reason_code           = (item.mode == MODE_FINISH) ? fin_reason : nx.reason;
      rsp.windows_opened        = nx.opened_count;
      rsp.fresh_total           = nx.fresh_count;
      rsp.change_total          = nx.change_count;
      rsp.recent_value          = nx.last_val;
      rsp.recent_stamp_ns       = nx.last_time;
      rsp.last_sample_state     = nx.last_freshness;
   end

endmodule

[sv/sustained_threshold_trigger.sv]
// top level of the sustained threshold trigger: item pipeline, rule state and registers
//
// Each poll or finish item yields exactly one result item. An accepted item sits in the
// input register while the rule logic evaluates it and moves into the result register
// once that register is empty or its result is taken; a new item is taken every cycle
// as long as the result side keeps up. The rule state updates once per item as it moves
// into the result register, which sets the rate at one item per cycle; while a result
// waits under stall, the item behind it holds in the input register and the input
// stalls. The hold time is converted to nanoseconds when the hold register is written,
// so the pending check is a single 63-bit subtract and compare. The user must write
// registers only while no item is in flight; the block itself does not enforce this.
module sustained_threshold_trigger (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  sst_pkg::req_type                     req_item,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output sst_pkg::rsp_type                     rsp_item,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sst_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [31:0]                          csr_data
);
   import sst_pkg::*;

   logic      in_valid_ff, in_valid_in;
   req_type   in_item_ff;
   logic      out_valid_ff, out_valid_in;
   rsp_type   out_item_ff;
   state_type state_ff, state_in;
   cfg_type   cfg_ff, cfg_in;

   logic      advance;
   logic      take_in;
   logic      csr_we;
   state_type rule_next;
   rsp_type   rule_rsp;

   function automatic state_type state_reset();
      state_type s;
      s       = '0;
      s.phase = PH_WARMING;
      return s;
   endfunction

   function automatic cfg_type cfg_reset();
      cfg_type c;
      c               = '0;
      c.window_budget = 7'd1;
      return c;
   endfunction

   sst_rule u_rule (
      .st   (state_ff),
      .item (in_item_ff),
      .cfg  (cfg_ff),
      .nx   (rule_next),
      .rsp  (rule_rsp)
   );

   always_comb begin
      advance      = in_valid_ff && (!out_valid_ff || !rsp_stall);
      req_stall    = in_valid_ff && !advance;
      take_in      = req_valid && !req_stall;
      in_valid_in  = take_in || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && rsp_stall);
      csr_ready    = 1'b1;
      csr_we       = csr_valid;
      rsp_valid    = out_valid_ff;
      rsp_item     = out_item_ff;
   end

   always_comb begin
      state_in = advance ? rule_next : state_ff;
      cfg_in   = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_RULE_SUPPORTED: begin
               if (!csr_data[0]) begin
                  state_in.phase   = PH_INACTIVE;
                  state_in.outcome = OC_UNSUPPORTED;
                  state_in.reason  = RS_UNSUPPORTED;
               end
            end
            CSR_COMPARE_LESS_THAN: cfg_in.compare_less_than = csr_data[0];
            CSR_THRESHOLD:         cfg_in.threshold         = csr_data;
            CSR_REARM_LEVEL:       cfg_in.rearm_level       = csr_data;
            CSR_HOLD_MS:           cfg_in.hold_ns           = HOLD_W'(csr_data[15:0]) *
                                                              HOLD_W'(NS_PER_MS);
            CSR_WINDOW_BUDGET:     cfg_in.window_budget     = csr_data[6:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= state_reset();
         cfg_ff       <= cfg_reset();
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_in) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff <= rule_rsp;
      end
   end

   // an inactive rule is only revived by reset
   assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_INACTIVE |=> state_ff.phase == PH_INACTIVE)
      else $error("rule left inactive phase");

   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> state_ff.opened_count >= $past(state_ff.opened_count))
      else $error("opened window count decreased");

   assert property (@(posedge clock) disable iff (reset)
      state_ff.outcome == OC_EXHAUSTED |=>
         state_ff.outcome == OC_EXHAUSTED || state_ff.outcome == OC_UNSUPPORTED)
      else $error("exhausted outcome lost");

   assert property (@(posedge clock) disable iff (reset)
      advance && rule_rsp.open_request |=>
         state_ff.phase == PH_OPENING || state_ff.phase == PH_ARMED)
      else $error("open request left rule in wrong phase");

endmodule
